// ----- design/bounded_navigation_history_defines.svh -----
// assertion macros for the navigation history block
`ifndef BOUNDED_NAVIGATION_HISTORY_DEFINES_SVH
`define BOUNDED_NAVIGATION_HISTORY_DEFINES_SVH

`ifndef SYNTHESIS

`define BNH_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bnh assertion failed");

`define BNH_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("bnh assertion failed");

`else

`define BNH_ASSERT(lbl, clk, rst_n, prop)

`define BNH_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- design/bnh_pkg.sv -----
package bnh_pkg;

	localparam int FUNC_W  = 3;
	localparam int FILE_W  = 16;
	localparam int LINE_W  = 24;
	localparam int COL_W   = 16;
	localparam int ENTRY_W = FILE_W + LINE_W + COL_W;
	localparam int TDATA_W = 64;

	localparam int DEF_MAX_DEPTH  = 32;
	localparam int DEF_CUT_AMOUNT = 8;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD   = 3'd0,
		FUNC_FWD   = 3'd1,
		FUNC_BACK  = 3'd2,
		FUNC_CUR   = 3'd3,
		FUNC_CLEAR = 3'd4
	} bnh_func_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} bnh_state_t;

	typedef struct packed {
		logic [FILE_W-1:0] file_id;
		logic [LINE_W-1:0] line;
		logic [COL_W-1:0]  column;
	} bnh_entry_t;

	typedef struct packed {
		logic              valid;
		logic              moved;
		logic [FILE_W-1:0] file_id;
		logic [LINE_W-1:0] line;
		logic [COL_W-1:0]  column;
		logic              can_back;
		logic              can_fwd;
	} bnh_result_t;

endpackage

// ----- design/bnh_ram.sv -----
module bnh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/bnh_ctrl.sv -----
module bnh_ctrl import bnh_pkg::*; #(
	parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
	parameter int CUT_AMOUNT = DEF_CUT_AMOUNT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [FUNC_W-1:0]            in_func,
	input  bnh_entry_t                   in_entry,
	input  logic                         out_free,
	output bnh_result_t                  res,
	output logic                         rd_en,
	output logic [$clog2(MAX_DEPTH)-1:0] rd_addr,
	input  logic [ENTRY_W-1:0]           rd_data,
	output logic                         wr_en,
	output logic [$clog2(MAX_DEPTH)-1:0] wr_addr,
	output logic [ENTRY_W-1:0]           wr_data
);

	localparam int PW      = $clog2(MAX_DEPTH);
	localparam int CW      = $clog2(MAX_DEPTH + 1);
	localparam int CUT_EFF = (CUT_AMOUNT < MAX_DEPTH) ? CUT_AMOUNT : MAX_DEPTH;
	localparam int ADV     = CUT_EFF % MAX_DEPTH;
	localparam int KEEP    = MAX_DEPTH - CUT_EFF;

	localparam logic [PW+1:0] DEPTH_X = (PW+2)'(MAX_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(MAX_DEPTH);
	localparam logic [CW-1:0] KEEP_C  = CW'(KEEP);
	localparam logic [PW:0]   ADV_I   = (PW+1)'(ADV);

	function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
			input logic [PW:0] idx);
		logic [PW+1:0] s;
		s = {2'b00, base} + {1'b0, idx};
		if (s >= DEPTH_X) begin
			s = s - DEPTH_X;
		end
		return s[PW-1:0];
	endfunction

	bnh_state_t        state_q, state_n;
	logic [PW-1:0]     oldest_q, oldest_n;
	logic [CW-1:0]     count_q, count_n;
	logic [PW-1:0]     cur_q, cur_n;
	logic [FUNC_W-1:0] func_q;
	bnh_entry_t        entry_q;

	bnh_entry_t    rd_entry;
	logic [CW-1:0] cur_c;
	logic [CW-1:0] cnt_t;
	logic [PW:0]   rd_idx;
	logic          has;
	logic          dup;
	logic          moved;
	logic          commit;

	assign rd_entry = bnh_entry_t'(rd_data);
	assign cur_c    = CW'(cur_q);
	assign has      = (count_q != '0);
	assign in_ready = (state_q == ST_IDLE);
	assign rd_en    = in_valid && in_ready;
	assign commit   = (state_q == ST_EXEC) && out_free;
	assign wr_data  = ENTRY_W'(entry_q);

	always_comb begin
		case (in_func)
			FUNC_FWD:  rd_idx = {1'b0, cur_q} + 1'b1;
			FUNC_BACK: rd_idx = {1'b0, cur_q} - 1'b1;
			default:   rd_idx = {1'b0, cur_q};
		endcase
		rd_addr = slot_of(oldest_q, rd_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			oldest_q <= '0;
			count_q  <= '0;
			cur_q    <= '0;
		end else begin
			state_q <= state_n;
			if (commit) begin
				oldest_q <= oldest_n;
				count_q  <= count_n;
				cur_q    <= cur_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			func_q  <= in_func;
			entry_q <= in_entry;
		end
	end

	always_comb begin
		state_n  = state_q;
		oldest_n = oldest_q;
		count_n  = count_q;
		cur_n    = cur_q;
		cnt_t    = '0;
		dup      = 1'b0;
		moved    = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = '0;

		case (state_q)
			ST_IDLE: begin
				if (rd_en) begin
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase

		case (func_q)
			FUNC_ADD: begin
				cnt_t   = has ? (cur_c + 1'b1) : '0;
				dup     = has && (rd_entry.file_id == entry_q.file_id) &&
					(rd_entry.line == entry_q.line);
				count_n = cnt_t;
				if (!dup) begin
					if (cnt_t >= DEPTH_C) begin
						oldest_n = slot_of(oldest_q, ADV_I);
						cnt_t    = KEEP_C;
					end
					wr_en   = commit;
					wr_addr = slot_of(oldest_n, (PW+1)'(cnt_t));
					count_n = cnt_t + 1'b1;
					cur_n   = cnt_t[PW-1:0];
				end
			end
			FUNC_FWD: begin
				if (has && ((cur_c + 1'b1) < count_q)) begin
					cur_n = cur_q + 1'b1;
					moved = 1'b1;
				end
			end
			FUNC_BACK: begin
				if (has && (cur_q != '0)) begin
					cur_n = cur_q - 1'b1;
					moved = 1'b1;
				end
			end
			FUNC_CUR: begin
				if (has && (cur_c < count_q)) begin
					moved = 1'b1;
				end
			end
			FUNC_CLEAR: begin
				count_n = '0;
				cur_n   = '0;
			end
			default: begin
			end
		endcase

		res.valid    = (state_q == ST_EXEC);
		res.moved    = moved;
		res.file_id  = moved ? rd_entry.file_id : '0;
		res.line     = moved ? rd_entry.line : '0;
		res.column   = moved ? rd_entry.column : '0;
		res.can_back = (count_n != '0) && (cur_n != '0);
		res.can_fwd  = (count_n != '0) && ((CW'(cur_n) + 1'b1) < count_n);
	end

endmodule

// ----- design/bounded_navigation_history.sv -----
// Back/forward navigation history holding up to MAX_DEPTH locations (file id, line,
// column) in one single-port-read memory. The accept cycle reads the entry a command needs
// (the current entry for an add, the jump target otherwise); the execute state then
// compares, updates the pointers and writes a new entry, and no new command is
// accepted until that command has finished. Every command gives one result transaction;
// the output register lets the next command in while a result waits, and the block
// holds a finished command only while that register is still full. An add that overflows
// the store drops the CUT_AMOUNT oldest entries (at most MAX_DEPTH).
`include "bounded_navigation_history_defines.svh"

module bounded_navigation_history import bnh_pkg::*; #(
	parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
	parameter int CUT_AMOUNT = DEF_CUT_AMOUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// func, file_id, line_number, column_number, zero fill
	input  logic [TDATA_W-1:0] s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	// moved, file_id_out, line_out, column_out, can_go_back, can_go_forward, zero fill
	output logic [TDATA_W-1:0] m_tdata
);

	localparam int PW = $clog2(MAX_DEPTH);

	bnh_entry_t    in_entry;
	bnh_result_t   res;
	bnh_result_t   res_q;
	logic          m_tvalid_q;
	logic          out_free;
	logic          rd_en;
	logic          wr_en;
	logic [PW-1:0] rd_addr;
	logic [PW-1:0] wr_addr;
	logic [ENTRY_W-1:0] rd_data;
	logic [ENTRY_W-1:0] wr_data;

	assign in_entry.file_id = s_tdata[18:3];
	assign in_entry.line    = s_tdata[42:19];
	assign in_entry.column  = s_tdata[58:43];

	assign out_free = !m_tvalid_q || m_tready;

	bnh_ctrl #(
		.MAX_DEPTH  (MAX_DEPTH),
		.CUT_AMOUNT (CUT_AMOUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_func  (s_tdata[2:0]),
		.in_entry (in_entry),
		.out_free (out_free),
		.res      (res),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	bnh_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b00000, res_q.can_fwd, res_q.can_back, res_q.column,
		res_q.line, res_q.file_id, res_q.moved};

	`BNH_ASSERT(a_one_per_two, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready)
	`BNH_ASSERT(a_res_held, clk, arst_n, (res.valid && !out_free) |=> res.valid)
	`BNH_ASSERT(a_no_move_zero, clk, arst_n, (m_tvalid && !m_tdata[0]) |-> (m_tdata[56:1] == '0))

endmodule
